/* hw/rtl/ngga_pkg.sv */
// Package for the GGA line parser: character codes and the classified word type.
// No dependencies.
package ngga_pkg;

  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_W      = 8'h57;
  localparam logic [33:0] DIG_LIMIT = 34'd999999999;

  // word as classified by the front end
  typedef struct packed {
    logic       is_cr;
    logic [7:0] ch;
  } ngga_item_t;

  function automatic logic [7:0] tag_char(input logic [2:0] pos);
    logic [7:0] r;
    begin
      r = 8'h00;
      case (pos)
        3'd0: r = CH_DOLLAR;
        3'd1: r = CH_G;
        3'd2: r = CH_P;
        3'd3: r = CH_G;
        3'd4: r = CH_G;
        3'd5: r = CH_A;
        default: r = 8'h00;
      endcase
      return r;
    end
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] r;
    begin
      r = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) r = 4'(c - 8'h30);
      else if (c >= 8'h41 && c <= 8'h46) r = 4'(c - 8'h37);
      return r;
    end
  endfunction

endpackage

/* hw/rtl/ngga_front.sv */
// Front end: filters printable bytes and CR into a two-entry queue.
// Depends on ngga_pkg.
module ngga_front
  import ngga_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       q_valid,
  input  logic       q_ready,
  output ngga_item_t q_item
);

  ngga_item_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       keep, push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign keep = (in_rx_byte == CH_CR) || (in_rx_byte >= 8'h20 && in_rx_byte <= 8'h7E);
  assign push = in_valid && in_ready && keep;
  assign q_valid = (cnt_r != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_item = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= '{is_cr: (in_rx_byte == CH_CR), ch: in_rx_byte};
    end
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef SYNTH
  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !push) else $error("queue overrun");
  a_cnt_rng: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count bad");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != 2'd0) else $error("pop from empty");
`endif

endmodule

/* hw/rtl/ngga_back.sv */
// Back end: per-line header match, checksum and token parse, one result per line.
// Depends on ngga_pkg.
module ngga_back
  import ngga_pkg::*;
#(
  parameter int LINE_BUFFER = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_ready,
  input  ngga_item_t  q_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_header_found,
  output logic        out_checksum_ok,
  output logic        out_fields_complete,
  output logic [6:0]  out_computed_sum,
  output logic [7:0]  out_received_sum,
  output logic [33:0] out_lat_digits,
  output logic [3:0]  out_lat_frac_count,
  output logic        out_lat_south,
  output logic [33:0] out_lon_digits,
  output logic [3:0]  out_lon_frac_count,
  output logic        out_lon_west,
  output logic [7:0]  out_fix_quality
);

  localparam int LW = $clog2(LINE_BUFFER + 1);
  localparam logic [LW-1:0] LEN_END = LW'(LINE_BUFFER - 1);

  logic [2:0]  hpos_r, hpos_nxt;
  logic        hseen_r, hseen_nxt;
  logic [6:0]  xor_r, xor_nxt;
  logic [23:0] l3_r, l3_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [2:0]  tok_r, tok_nxt;
  logic        intok_r, intok_nxt;
  logic [33:0] lat_r, lat_nxt, lon_r, lon_nxt;
  logic [5:0]  latf_r, latf_nxt, lonf_r, lonf_nxt;
  logic        south_r, south_nxt, west_r, west_nxt;
  logic [7:0]  fix_r, fix_nxt;
  logic        ov_r;
  logic        emit, take, ok;
  logic [7:0]  c;
  logic        isdig;
  logic [7:0]  rx;
  logic [11:0] fixv;

  // one coordinate character; f = {frac[3:0], stop, point}
  function automatic logic [39:0] coord(input logic [33:0] acc, input logic [5:0] f,
                                        input logic [7:0] ch);
    logic [33:0] a;
    logic [5:0]  g;
    begin
      a = acc;
      g = f;
      if (!f[1]) begin
        if (ch == CH_POINT) begin
          if (f[0]) g[1] = 1'b1; else g[0] = 1'b1;
        end else if (ch >= 8'h30 && ch <= 8'h39) begin
          if (acc > DIG_LIMIT) g[1] = 1'b1;
          else begin
            a = 34'((acc << 3) + (acc << 1) + {26'd0, ch - 8'h30});
            if (f[0]) g[5:2] = f[5:2] + 4'd1;
          end
        end else g[1] = 1'b1;
      end
      return {g, a};
    end
  endfunction

  assign q_ready = !ov_r || out_ready;
  assign take = q_valid && q_ready;
  assign c = q_item.ch;
  assign isdig = (c >= 8'h30 && c <= 8'h39);
  // fix * 10 + digit, wide enough for a saturated 255 followed by a digit
  assign fixv = 12'({fix_r, 3'b000}) + 12'({fix_r, 1'b0}) + {4'd0, c - 8'h30};

  // next line state; a CR leaves it as it is, so the result always reads the _nxt values
  always_comb begin
    hpos_nxt = hpos_r; hseen_nxt = hseen_r; xor_nxt = xor_r; l3_nxt = l3_r;
    len_nxt = len_r; tok_nxt = tok_r; intok_nxt = intok_r;
    lat_nxt = lat_r; lon_nxt = lon_r; latf_nxt = latf_r; lonf_nxt = lonf_r;
    south_nxt = south_r; west_nxt = west_r; fix_nxt = fix_r;
    emit = 1'b0;
    if (q_item.is_cr) begin
      emit = 1'b1;
    end else begin
      len_nxt = len_r + LW'(1);
      if (!hseen_r) begin
        if (hpos_r < 3'd6 && c == tag_char(hpos_r)) hpos_nxt = hpos_r + 3'd1;
        else hpos_nxt = (c == CH_DOLLAR) ? 3'd1 : 3'd0;
        if (hpos_nxt == 3'd6) begin
          hseen_nxt = 1'b1;
          xor_nxt = 7'(CH_G ^ CH_P);
          l3_nxt = {CH_G, CH_G, CH_A};
          tok_nxt = 3'd0;
          intok_nxt = 1'b1;
        end
      end else begin
        xor_nxt = xor_r ^ l3_r[22:16];
        l3_nxt = {l3_r[15:0], c};
        if (c == CH_COMMA) intok_nxt = 1'b0;
        else begin
          if (!intok_r) begin
            intok_nxt = 1'b1;
            if (tok_r < 3'd7) tok_nxt = tok_r + 3'd1;
            if (tok_nxt == 3'd3 && c == CH_S) south_nxt = 1'b1;
            if (tok_nxt == 3'd5 && c == CH_W) west_nxt = 1'b1;
          end
          if (tok_nxt == 3'd2) {latf_nxt, lat_nxt} = coord(lat_r, latf_r, c);
          else if (tok_nxt == 3'd4) {lonf_nxt, lon_nxt} = coord(lon_r, lonf_r, c);
          else if (tok_nxt == 3'd6) begin
            if (isdig) fix_nxt = (fixv > 12'd255) ? 8'd255 : fixv[7:0];
            else tok_nxt = 3'd7;
          end
        end
      end
      if (len_nxt >= LEN_END) emit = 1'b1;
    end
  end

  assign rx = {hex_val(l3_nxt[15:8]), hex_val(l3_nxt[7:0])};
  assign ok = hseen_nxt && (xor_nxt == rx[6:0]) && !rx[7];

  always_ff @(posedge clk) begin
    if (take && emit) begin
      out_header_found    <= hseen_nxt;
      out_checksum_ok     <= ok;
      out_fields_complete <= ok && (tok_nxt >= 3'd6);
      out_computed_sum    <= hseen_nxt ? xor_nxt : 7'd0;
      out_received_sum    <= hseen_nxt ? rx : 8'd0;
      out_lat_digits      <= ok ? lat_nxt : '0;
      out_lat_frac_count  <= ok ? latf_nxt[5:2] : '0;
      out_lat_south       <= ok && south_nxt;
      out_lon_digits      <= ok ? lon_nxt : '0;
      out_lon_frac_count  <= ok ? lonf_nxt[5:2] : '0;
      out_lon_west        <= ok && west_nxt;
      out_fix_quality     <= ok ? fix_nxt : '0;
    end
    if (!rst_n) begin
      ov_r <= 1'b0; hseen_r <= 1'b0; len_r <= '0;
      hpos_r <= '0; xor_r <= '0; l3_r <= '0; tok_r <= '0; intok_r <= 1'b0;
      lat_r <= '0; lon_r <= '0; latf_r <= '0; lonf_r <= '0;
      south_r <= 1'b0; west_r <= 1'b0; fix_r <= '0;
    end else begin
      if (take && emit) begin
        hseen_r <= 1'b0; len_r <= '0;
        hpos_r <= '0; xor_r <= '0; l3_r <= '0; tok_r <= '0; intok_r <= 1'b0;
        lat_r <= '0; lon_r <= '0; latf_r <= '0; lonf_r <= '0;
        south_r <= 1'b0; west_r <= 1'b0; fix_r <= '0;
      end else if (take) begin
        hseen_r <= hseen_nxt; len_r <= len_nxt;
        hpos_r <= hpos_nxt; xor_r <= xor_nxt; l3_r <= l3_nxt;
        tok_r <= tok_nxt; intok_r <= intok_nxt;
        lat_r <= lat_nxt; lon_r <= lon_nxt; latf_r <= latf_nxt; lonf_r <= lonf_nxt;
        south_r <= south_nxt; west_r <= west_nxt; fix_r <= fix_nxt;
      end
      if (take && emit) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  assign out_valid = ov_r;

`ifndef SYNTH
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_ready |=> ov_r) else $error("result dropped");
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    len_r < LEN_END) else $error("line length past end");
  a_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    !hseen_r |-> tok_r == 3'd0) else $error("tokens before header");
`endif

endmodule

/* hw/rtl/nmea_gga_line_parser_unit.sv */
// Top level of the GGA line parser: front filter, queue and back-end parser.
// Depends on ngga_pkg, ngga_front, ngga_back.
//
//  channel | ports                         | dir
//  in      | in_valid/in_ready/in_rx_byte  | byte from serial link
//  out     | out_valid/out_ready/out_*     | one result per line
//
// One byte a cycle while in_ready is high. The CR or the final kept byte of a line
// passes the queue entry, then the back-end result register, which raises out_valid.
// Front stage drops non-printable bytes and fills a two-word queue while it has room.
// Back end updates line state per word taken; while a result waits it takes no
// words, so the queue fills and in_ready drops. Synchronous active-low reset.
module nmea_gga_line_parser_unit
  import ngga_pkg::*;
#(
  parameter int LINE_BUFFER = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_header_found,
  output logic        out_checksum_ok,
  output logic        out_fields_complete,
  output logic [6:0]  out_computed_sum,
  output logic [7:0]  out_received_sum,
  output logic [33:0] out_lat_digits,
  output logic [3:0]  out_lat_frac_count,
  output logic        out_lat_south,
  output logic [33:0] out_lon_digits,
  output logic [3:0]  out_lon_frac_count,
  output logic        out_lon_west,
  output logic [7:0]  out_fix_quality
);

  logic       q_valid, q_ready;
  ngga_item_t q_item;

  ngga_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_rx_byte,
    .q_valid, .q_ready, .q_item
  );

  ngga_back #(.LINE_BUFFER(LINE_BUFFER)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_item,
    .out_valid, .out_ready, .out_header_found, .out_checksum_ok,
    .out_fields_complete, .out_computed_sum, .out_received_sum,
    .out_lat_digits, .out_lat_frac_count, .out_lat_south,
    .out_lon_digits, .out_lon_frac_count, .out_lon_west, .out_fix_quality
  );

endmodule
